// ===== hw/rtl/rtd_pkg.sv =====
// Shared types, constants and the order-word update for the rotation detector.
// Depends on nothing; used by rtd_hyst_cmp and the top level.
package rtd_pkg;

    // Rotation codes.
    localparam logic [1:0] DIR_UNKNOWN = 2'd0;
    localparam logic [1:0] DIR_RIGHT   = 2'd1;
    localparam logic [1:0] DIR_LEFT    = 2'd2;

    // Hysteresis half band after reset, in ADC counts.
    localparam int THR_RESET = 100;

    // Order words that identify each rotation, phase codes packed from the low bits.
    localparam logic [5:0] RIGHT_WORD0 = 6'h39;
    localparam logic [5:0] RIGHT_WORD1 = 6'h1E;
    localparam logic [5:0] RIGHT_WORD2 = 6'h27;
    localparam logic [5:0] LEFT_WORD0  = 6'h2D;
    localparam logic [5:0] LEFT_WORD1  = 6'h36;
    localparam logic [5:0] LEFT_WORD2  = 6'h1B;

    localparam logic [1:0] LAST_POS = 2'd3;

    typedef struct packed {
        logic rise;
        logic fall;
    } cross_t;

    typedef struct packed {
        logic [5:0] word;
        logic [1:0] count;
        logic [1:0] dir;
        logic       done;
    } order_t;

    function automatic logic [1:0] match_word(input logic [5:0] word);
        logic [1:0] d;
        d = DIR_UNKNOWN;
        if (word == RIGHT_WORD0 || word == RIGHT_WORD1 || word == RIGHT_WORD2) begin
            d = DIR_RIGHT;
        end
        else if (word == LEFT_WORD0 || word == LEFT_WORD1 || word == LEFT_WORD2) begin
            d = DIR_LEFT;
        end
        return d;
    endfunction

    // Appends one phase code; the third code completes a decision and clears the word.
    function automatic order_t add_code(input order_t st, input logic [1:0] code);
        order_t r;
        r = st;
        case (st.count)
            2'd0:    r.word = st.word | {4'b0000, code};
            2'd1:    r.word = st.word | {2'b00, code, 2'b00};
            2'd2:    r.word = st.word | {code, 4'b0000};
            default: r.word = st.word;
        endcase
        r.count = st.count + 2'd1;
        if (r.count == LAST_POS) begin
            r.dir   = match_word(r.word);
            r.word  = 6'd0;
            r.count = 2'd0;
            r.done  = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/rtd_hyst_cmp.sv =====
// Hysteresis zero-crossing comparator for one phase against neutral.
// Depends on rtd_pkg for the crossing struct.
module rtd_hyst_cmp
    import rtd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic [SAMPLE_BITS-1:0] phase_sample,
    input  logic [SAMPLE_BITS-1:0] neutral_sample,
    input  logic [SAMPLE_BITS-1:0] threshold,
    input  logic                   polarity,
    output cross_t                 xing
);

    localparam int VW = SAMPLE_BITS + 2;

    logic signed [VW-1:0] volt;
    logic signed [VW-1:0] thr_pos;
    logic signed [VW-1:0] thr_neg;

    assign volt    = signed'({2'b00, phase_sample}) - signed'({2'b00, neutral_sample});
    assign thr_pos = signed'({2'b00, threshold});
    assign thr_neg = -thr_pos;

    // Both bounds are inclusive, so a zero band toggles on a zero voltage.
    assign xing.rise = !polarity && (volt >= thr_pos);
    assign xing.fall = polarity && (volt <= thr_neg);

endmodule

// ===== hw/rtl/three_phase_rotation_detector_top.sv =====
// Three-phase rotation detector: hysteresis crossing per phase and order-word decode.
// Depends on rtd_pkg and rtd_hyst_cmp.
//
//  channel | signals                                           | dir
//  --------+---------------------------------------------------+-----
//  in      | in_valid/in_ready, l1/l2/l3/neutral_sample        | in
//  out     | out_valid/out_ready, rotation, rotation_updated,  | out
//          | rising_mask                                       |
//  cfg     | cfg_valid/cfg_ready, zero_cross_threshold         | in
//
// One beat per cycle sustained while out_ready holds; a beat's result passes through the
// input register, then the comparator and order logic into the result register. Reset
// sets all polarities positive, clears the order word and its direction (not the rotation
// output register), and loads the band with 100. A stalled output holds the input
// register, which then stalls in.
module three_phase_rotation_detector_top
    import rtd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] l1_sample,
    input  logic [SAMPLE_BITS-1:0] l2_sample,
    input  logic [SAMPLE_BITS-1:0] l3_sample,
    input  logic [SAMPLE_BITS-1:0] neutral_sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             rotation,
    output logic                   rotation_updated,
    output logic [2:0]             rising_mask,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [SAMPLE_BITS-1:0] zero_cross_threshold
);

    localparam logic [SAMPLE_BITS-1:0] ThrResetVal = SAMPLE_BITS'(THR_RESET);

    logic                   s1_valid_reg, s1_valid_next;
    logic [SAMPLE_BITS-1:0] ph_reg [3];
    logic [SAMPLE_BITS-1:0] neu_reg;
    logic [SAMPLE_BITS-1:0] thr_reg;
    logic [2:0]             pol_reg, pol_next;
    logic [5:0]             word_reg;
    logic [1:0]             count_reg;
    logic [1:0]             dir_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             rot_reg;
    logic                   upd_reg;
    logic [2:0]             mask_reg;
    logic                   advance;
    logic                   in_fire;
    cross_t                 xing [3];
    order_t                 ord_next;
    logic [2:0]             mask_next;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    for (genvar k = 0; k < 3; k++) begin : g_cmp
        rtd_hyst_cmp #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cmp (
            .phase_sample  (ph_reg[k]),
            .neutral_sample(neu_reg),
            .threshold     (thr_reg),
            .polarity      (pol_reg[k]),
            .xing          (xing[k])
        );
    end

    // Crossings are taken in phase order; a decision may complete mid-sample and the
    // later codes then start a fresh word.
    always_comb
    begin
        order_t st;
        st.word  = word_reg;
        st.count = count_reg;
        st.dir   = dir_reg;
        st.done  = 1'b0;
        pol_next  = pol_reg;
        mask_next = 3'b000;
        for (int k = 0; k < 3; k++) begin
            if (xing[k].rise) begin
                pol_next[k]  = 1'b1;
                mask_next[k] = 1'b1;
                st = add_code(st, 2'(k + 1));
            end
            else if (xing[k].fall) begin
                pol_next[k] = 1'b0;
            end
        end
        ord_next = st;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire) begin
            s1_valid_next = 1'b1;
        end
        else if (advance) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            thr_reg       <= ThrResetVal;
            pol_reg       <= 3'b111;
            word_reg      <= 6'd0;
            count_reg     <= 2'd0;
            dir_reg       <= DIR_UNKNOWN;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                thr_reg <= zero_cross_threshold;
            end
            if (advance) begin
                pol_reg   <= pol_next;
                word_reg  <= ord_next.word;
                count_reg <= ord_next.count;
                dir_reg   <= ord_next.dir;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            ph_reg[0] <= l1_sample;
            ph_reg[1] <= l2_sample;
            ph_reg[2] <= l3_sample;
            neu_reg   <= neutral_sample;
        end
        if (advance) begin
            rot_reg  <= ord_next.dir;
            upd_reg  <= ord_next.done;
            mask_reg <= mask_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign rotation         = rot_reg;
    assign rotation_updated = upd_reg;
    assign rising_mask      = mask_reg;

endmodule

// ===== hw/rtl/rtd_checker.sv =====
// Port-level checks for the rotation detector, bound to the top level.
// Depends only on the top level's ports.
module rtd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] rotation,
    input logic       rotation_updated,
    input logic [2:0] rising_mask
);

    logic       seen_reg;
    logic [1:0] last_rot_reg;

    // Rotation reported by the most recent delivered beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seen_reg     <= 1'b0;
            last_rot_reg <= 2'd0;
        end
        else if (out_valid && out_ready) begin
            seen_reg     <= 1'b1;
            last_rot_reg <= rotation;
        end
    end

    // Rotation can only change on a beat that completes a decision.
    a_rot_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg && !rotation_updated |-> rotation == last_rot_reg)
        else $error("rotation changed without a decision");

    // A decision needs a rising crossing in the same sample.
    a_upd_needs_rise: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rotation_updated |-> rising_mask != 3'b000)
        else $error("decision reported without a rising crossing");

    // Once reset has been seen at an edge, the result register is empty at the next one.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid after reset");

    // A stalled result keeps its beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rotation)
            && $stable(rotation_updated) && $stable(rising_mask))
        else $error("stalled result changed");

endmodule

bind three_phase_rotation_detector_top rtd_checker u_rtd_checker (.*);
